@@ sv/tpt_pkg.sv @@
// Shared constants and types for the page table translator.
// Used by tpt_tlb and tlb_page_table_translator; depends on nothing.
`timescale 1ns / 1ps

package tpt_pkg;

	localparam int TLB_DEPTH   = 16;
	localparam int TLB_IDX_W   = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;
	localparam int TLB_CNT_W   = $clog2(TLB_DEPTH + 1);
	localparam int MAX_FRAMES  = 256;
	localparam int FCNT_W      = $clog2(MAX_FRAMES + 1);
	localparam int FRAME_W     = 8;
	localparam int PAGE_W      = 8;
	localparam int OFFSET_BITS = 8;
	localparam int PAGES       = 1 << PAGE_W;
	localparam int STAMP_W     = 32;
	localparam int CTR_W       = 32;

	// Update request to the TLB: append an entry, or drop the entry of a page.
	typedef struct packed {
		logic              ins;
		logic              rem;
		logic [PAGE_W-1:0] page;
		logic [FRAME_W-1:0] frame;
	} tlb_cmd_t;

	typedef struct packed {
		logic               hit;
		logic [FRAME_W-1:0] frame;
	} tlb_res_t;

endpackage

@@ sv/tpt_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module tpt_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 8,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [ADDR_W-1:0]        waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [ADDR_W-1:0]        raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ sv/tpt_tlb.sv @@
// FIFO TLB held in registers: parallel lookup, append with oldest-drop, and
// removal of one page with compaction. Depends on tpt_pkg.
`timescale 1ns / 1ps

module tpt_tlb (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [tpt_pkg::PAGE_W-1:0]  look_page,
	output tpt_pkg::tlb_res_t           look,
	input  tpt_pkg::tlb_cmd_t           cmd
);
	logic [tpt_pkg::PAGE_W-1:0]    page_q  [tpt_pkg::TLB_DEPTH];
	logic [tpt_pkg::FRAME_W-1:0]   frame_q [tpt_pkg::TLB_DEPTH];
	logic [tpt_pkg::TLB_CNT_W-1:0] fill_q;
	logic                          rem_hit;
	logic [tpt_pkg::TLB_IDX_W-1:0] rem_idx;

	// Descending scan so that the lowest matching index wins.
	always_comb begin
		look    = '0;
		rem_hit = 1'b0;
		rem_idx = '0;
		for (int i = tpt_pkg::TLB_DEPTH - 1; i >= 0; i--) begin
			if (tpt_pkg::TLB_CNT_W'(i) < fill_q && page_q[i] == look_page) begin
				look.hit   = 1'b1;
				look.frame = frame_q[i];
			end
			if (tpt_pkg::TLB_CNT_W'(i) < fill_q && page_q[i] == cmd.page) begin
				rem_hit = 1'b1;
				rem_idx = tpt_pkg::TLB_IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (fill_q == tpt_pkg::TLB_CNT_W'(tpt_pkg::TLB_DEPTH)) begin
				for (int i = 0; i < tpt_pkg::TLB_DEPTH - 1; i++) begin
					page_q[i]  <= page_q[i+1];
					frame_q[i] <= frame_q[i+1];
				end
				page_q[tpt_pkg::TLB_DEPTH-1]  <= cmd.page;
				frame_q[tpt_pkg::TLB_DEPTH-1] <= cmd.frame;
			end else begin
				page_q[fill_q[tpt_pkg::TLB_IDX_W-1:0]]  <= cmd.page;
				frame_q[fill_q[tpt_pkg::TLB_IDX_W-1:0]] <= cmd.frame;
			end
		end else if (cmd.rem && rem_hit) begin
			for (int i = 0; i < tpt_pkg::TLB_DEPTH - 1; i++) begin
				if (tpt_pkg::TLB_IDX_W'(i) >= rem_idx) begin
					page_q[i]  <= page_q[i+1];
					frame_q[i] <= frame_q[i+1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cmd.ins) begin
			if (fill_q != tpt_pkg::TLB_CNT_W'(tpt_pkg::TLB_DEPTH)) begin
				fill_q <= fill_q + 1'b1;
			end
		end else if (cmd.rem && rem_hit) begin
			fill_q <= fill_q - 1'b1;
		end
	end

endmodule

@@ sv/tlb_page_table_translator.sv @@
// Top level of the demand-paging translator: control sequencer, counters,
// frame/stamp memories. Depends on tpt_pkg, tpt_ram and tpt_tlb.
`timescale 1ns / 1ps

// A TLB hit passes through LOOK and OUT, a page table hit through LOOK, PT and
// OUT, a fault into a free frame adds FILL, and a fault with replacement adds
// SCAN, VRD and VIC; SCAN reads the stamp memory one frame per cycle up to limit.
// One item is in flight at a time; the next beat is taken once the result is
// in the output register. Reset clears the TLB fill, the page valid bits,
// all counters, and sets num_frames to 256; memories are not cleared.
module tlb_page_table_translator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] virtual_address,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  frame_number,
	output logic [15:0] physical_address,
	output logic [7:0]  page_number,
	output logic        tlb_hit,
	output logic        page_fault,
	output logic [31:0] hits_so_far,
	output logic [31:0] faults_so_far,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [8:0]  num_frames
);
	// Sequencer states. LOOK probes the TLB and reads the page-to-frame map,
	// PT resolves a table hit or a fault, SCAN walks the stamps for the least
	// recently used frame, VRD/VIC fetch and evict its old page, FILL installs.
	typedef enum logic [2:0] {
		S_IDLE, S_LOOK, S_PT, S_SCAN, S_VRD, S_VIC, S_FILL, S_OUT
	} state_t;

	state_t state_q;

	logic [tpt_pkg::PAGE_W-1:0]      page_q;
	logic [tpt_pkg::OFFSET_BITS-1:0] offset_q;
	logic [tpt_pkg::FRAME_W-1:0]     frame_q;
	logic                            hit_q;
	logic                            fault_q;
	logic [tpt_pkg::FCNT_W-1:0]      num_frames_q;
	logic [tpt_pkg::FCNT_W-1:0]      frames_used_q;
	logic [tpt_pkg::STAMP_W-1:0]     access_q;
	logic [tpt_pkg::CTR_W-1:0]       hits_q;
	logic [tpt_pkg::CTR_W-1:0]       faults_q;
	logic [tpt_pkg::PAGES-1:0]       pvalid_q;

	// Replacement scan registers.
	logic [tpt_pkg::FCNT_W-1:0]      scan_addr_q;
	logic                            pend_s1;
	logic [tpt_pkg::FRAME_W-1:0]     idx_s1;
	logic                            any_q;
	logic [tpt_pkg::STAMP_W-1:0]     min_q;
	logic [tpt_pkg::FRAME_W-1:0]     best_q;

	logic                            out_valid_q;
	logic [tpt_pkg::FRAME_W-1:0]     frame_number_q;
	logic [15:0]                     physical_address_q;
	logic [tpt_pkg::PAGE_W-1:0]      page_number_q;
	logic                            tlb_hit_q;
	logic                            page_fault_q;
	logic [tpt_pkg::CTR_W-1:0]       hits_so_far_q;
	logic [tpt_pkg::CTR_W-1:0]       faults_so_far_q;

	logic [tpt_pkg::FCNT_W-1:0]      limit;
	logic [tpt_pkg::STAMP_W-1:0]     stamp;
	logic                            scan_issue;

	tpt_pkg::tlb_res_t               tlb_look;
	tpt_pkg::tlb_cmd_t               tlb_cmd;

	logic                            st_we;
	logic [tpt_pkg::FRAME_W-1:0]     st_waddr;
	logic [tpt_pkg::STAMP_W-1:0]     st_rdata;
	logic                            fop_we;
	logic                            fop_re;
	logic [tpt_pkg::FRAME_W-1:0]     fop_rdata;
	logic                            pof_we;
	logic                            pof_re;
	logic [tpt_pkg::PAGE_W-1:0]      pof_rdata;

	// Effective frame limit: zero acts as one, anything above the frame count
	// is clamped to it.
	always_comb begin
		limit = num_frames_q;
		if (num_frames_q == '0) begin
			limit = tpt_pkg::FCNT_W'(1);
		end else if (num_frames_q > tpt_pkg::FCNT_W'(tpt_pkg::MAX_FRAMES)) begin
			limit = tpt_pkg::FCNT_W'(tpt_pkg::MAX_FRAMES);
		end
	end

	assign stamp      = (access_q == '1) ? access_q : access_q + 1'b1;
	assign scan_issue = (state_q == S_SCAN) && (scan_addr_q < limit);

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;

	// Memory and TLB control follows directly from the sequencer state.
	always_comb begin
		tlb_cmd  = '0;
		st_we    = 1'b0;
		st_waddr = frame_q;
		fop_we   = 1'b0;
		pof_we   = 1'b0;
		fop_re   = (state_q == S_LOOK);
		pof_re   = (state_q == S_VRD);
		unique case (state_q)
			S_LOOK: begin
				if (tlb_look.hit) begin
					st_we    = 1'b1;
					st_waddr = tlb_look.frame;
				end
			end
			S_PT: begin
				// A page found in the map gets a TLB entry and a fresh stamp.
				if (pvalid_q[page_q]) begin
					st_we         = 1'b1;
					st_waddr      = fop_rdata;
					tlb_cmd.ins   = 1'b1;
					tlb_cmd.page  = page_q;
					tlb_cmd.frame = fop_rdata;
				end
			end
			S_VIC: begin
				// Drop any TLB entry of the page leaving the victim frame.
				tlb_cmd.rem  = 1'b1;
				tlb_cmd.page = pof_rdata;
			end
			S_FILL: begin
				st_we         = 1'b1;
				fop_we        = 1'b1;
				pof_we        = 1'b1;
				tlb_cmd.ins   = 1'b1;
				tlb_cmd.page  = page_q;
				tlb_cmd.frame = frame_q;
			end
			default: begin
			end
		endcase
	end

	tpt_tlb u_tlb (
		.clk       (clk),
		.arst_n    (arst_n),
		.look_page (page_q),
		.look      (tlb_look),
		.cmd       (tlb_cmd)
	);

	// Last-use stamp of each frame.
	tpt_ram #(.DEPTH(tpt_pkg::MAX_FRAMES), .WIDTH(tpt_pkg::STAMP_W)) u_stamp_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (stamp),
		.re    (scan_issue),
		.raddr (scan_addr_q[tpt_pkg::FRAME_W-1:0]),
		.rdata (st_rdata)
	);

	// Page-to-frame map; its entries count only where pvalid_q is set.
	tpt_ram #(.DEPTH(tpt_pkg::PAGES), .WIDTH(tpt_pkg::FRAME_W)) u_frame_of_page (
		.clk   (clk),
		.we    (fop_we),
		.waddr (page_q),
		.wdata (frame_q),
		.re    (fop_re),
		.raddr (page_q),
		.rdata (fop_rdata)
	);

	// Frame-to-page table, read only to find the page a victim frame holds.
	tpt_ram #(.DEPTH(tpt_pkg::MAX_FRAMES), .WIDTH(tpt_pkg::PAGE_W)) u_page_of_frame (
		.clk   (clk),
		.we    (pof_we),
		.waddr (frame_q),
		.wdata (page_q),
		.re    (pof_re),
		.raddr (frame_q),
		.rdata (pof_rdata)
	);

	// Residency bits per page: set on install, cleared on eviction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pvalid_q <= '0;
		end else if (state_q == S_FILL) begin
			pvalid_q[page_q] <= 1'b1;
		end else if (state_q == S_VIC) begin
			pvalid_q[pof_rdata] <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			num_frames_q  <= tpt_pkg::FCNT_W'(tpt_pkg::MAX_FRAMES);
			frames_used_q <= '0;
			access_q      <= '0;
			hits_q        <= '0;
			faults_q      <= '0;
			out_valid_q   <= 1'b0;
			pend_s1       <= 1'b0;
			any_q         <= 1'b0;
			scan_addr_q   <= '0;
		end else begin
			if (cfg_valid) begin
				num_frames_q <= num_frames;
			end
			// In S_OUT the output register is reloaded below instead.
			if (out_valid_q && out_ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			pend_s1 <= scan_issue;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						page_q   <= virtual_address[15:tpt_pkg::OFFSET_BITS];
						offset_q <= virtual_address[tpt_pkg::OFFSET_BITS-1:0];
						hit_q    <= 1'b0;
						fault_q  <= 1'b0;
						state_q  <= S_LOOK;
					end
				end
				S_LOOK: begin
					if (tlb_look.hit) begin
						frame_q  <= tlb_look.frame;
						hit_q    <= 1'b1;
						hits_q   <= (hits_q == '1) ? hits_q : hits_q + 1'b1;
						access_q <= stamp;
						state_q  <= S_OUT;
					end else begin
						state_q <= S_PT;
					end
				end
				S_PT: begin
					if (pvalid_q[page_q]) begin
						frame_q  <= fop_rdata;
						access_q <= stamp;
						state_q  <= S_OUT;
					end else begin
						fault_q  <= 1'b1;
						faults_q <= (faults_q == '1) ? faults_q : faults_q + 1'b1;
						if (frames_used_q < limit) begin
							frame_q       <= frames_used_q[tpt_pkg::FRAME_W-1:0];
							frames_used_q <= frames_used_q + 1'b1;
							state_q       <= S_FILL;
						end else begin
							scan_addr_q <= '0;
							any_q       <= 1'b0;
							state_q     <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (scan_issue) begin
						idx_s1      <= scan_addr_q[tpt_pkg::FRAME_W-1:0];
						scan_addr_q <= scan_addr_q + 1'b1;
					end
					// Ties go to the later frame, hence the less-or-equal.
					if (pend_s1 && (!any_q || st_rdata <= min_q)) begin
						min_q  <= st_rdata;
						best_q <= idx_s1;
						any_q  <= 1'b1;
					end
					if (!scan_issue && !pend_s1) begin
						frame_q <= best_q;
						state_q <= S_VRD;
					end
				end
				S_VRD: begin
					state_q <= S_VIC;
				end
				S_VIC: begin
					state_q <= S_FILL;
				end
				S_FILL: begin
					access_q <= stamp;
					state_q  <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q        <= 1'b1;
						frame_number_q     <= frame_q;
						physical_address_q <= {frame_q, offset_q};
						page_number_q      <= page_q;
						tlb_hit_q          <= hit_q;
						page_fault_q       <= fault_q;
						hits_so_far_q      <= hits_q;
						faults_so_far_q    <= faults_q;
						state_q            <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid        = out_valid_q;
	assign frame_number     = frame_number_q;
	assign physical_address = physical_address_q;
	assign page_number      = page_number_q;
	assign tlb_hit          = tlb_hit_q;
	assign page_fault       = page_fault_q;
	assign hits_so_far      = hits_so_far_q;
	assign faults_so_far    = faults_so_far_q;

	a_frames_bound: assert property (@(posedge clk) disable iff (!arst_n)
		frames_used_q <= tpt_pkg::FCNT_W'(tpt_pkg::MAX_FRAMES))
		else $error("frame count beyond frame table");

	a_hit_xor_fault: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(tlb_hit_q && page_fault_q))
		else $error("result flagged as both TLB hit and fault");

	a_scan_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_SCAN) |=> !pend_s1)
		else $error("stamp read pending outside the replacement scan");

	a_fill_on_fault: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FILL) |-> (fault_q && !pvalid_q[page_q]))
		else $error("installing a page that is already resident");

endmodule
